FILE: rtl/core/motion_safety_supervisor_defines.svh
// ----------------------------------------------------------------------------
// Motion safety supervisor assertion macros
// Concurrent assertion wrappers used by the supervisor RTL.
// ----------------------------------------------------------------------------
`ifndef MOTION_SAFETY_SUPERVISOR_DEFINES_SVH
`define MOTION_SAFETY_SUPERVISOR_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define MSUP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define MSUP_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define MSUP_ASSERT(label, clk, rst, prop, msg)
`define MSUP_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

FILE: rtl/core/msup_pkg.sv
// ----------------------------------------------------------------------------
// Motion safety supervisor package
// Shared types, codes and constants for the supervisor blocks.
// ----------------------------------------------------------------------------
package msup_pkg;

   localparam int MSUP_QUEUE_DEPTH = 2;
   localparam int CSR_DATA_W       = 48;
   localparam int CSR_INDEX_W      = 3;
   localparam int NUM_CHECKS       = 5;

   localparam logic [2:0] OP_TICK          = 3'd0;
   localparam logic [2:0] OP_FORCE_ESTOP   = 3'd1;
   localparam logic [2:0] OP_RELEASE_ESTOP = 3'd2;
   localparam logic [2:0] OP_CLEAR_FAULTS  = 3'd3;
   localparam logic [2:0] OP_RESET_STATS   = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_MASK     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLL_THRESHOLD  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_CEILING   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRAVEL_MIN      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRAVEL_MAX      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZONE_POS_MIN    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZONE_POS_MAX    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZONE_SPEED_BAND = 3'd7;

   localparam int FLAG_ESTOP     = 0;
   localparam int FLAG_COLLISION = 1;
   localparam int FLAG_SPEED     = 2;
   localparam int FLAG_POSITION  = 3;
   localparam int FLAG_ZONE      = 4;

   typedef enum logic [2:0] {
      CMD_TICK,
      CMD_FORCE_ESTOP,
      CMD_RELEASE_ESTOP,
      CMD_CLEAR_FAULTS,
      CMD_RESET_STATS,
      CMD_REPORT
   } cmd_type;

   typedef enum logic [1:0] {
      STATE_SAFE      = 2'd0,
      STATE_WARNING   = 2'd1,
      STATE_VIOLATION = 2'd2,
      STATE_EMERGENCY = 2'd3
   } safety_type;

   typedef enum logic [2:0] {
      FAULT_NONE      = 3'd0,
      FAULT_ESTOP     = 3'd1,
      FAULT_COLLISION = 3'd2,
      FAULT_SPEED     = 3'd3,
      FAULT_POSITION  = 3'd4
   } fault_type;

   typedef struct packed {
      logic [4:0]         enable_mask;
      logic [23:0]        collision_threshold;
      logic [22:0]        speed_ceiling;
      logic signed [31:0] travel_min;
      logic signed [31:0] travel_max;
      logic signed [31:0] zone_pos_min;
      logic signed [31:0] zone_pos_max;
      logic [47:0]        zone_speed_band;
   } cfg_type;

   typedef struct packed {
      cmd_type            cmd;
      logic               estop_level;
      logic               coll_hit;
      logic [23:0]        speed_mag;
      logic               over_hit;
      logic signed [31:0] position;
      logic               travel_hit;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

FILE: rtl/core/msup_if.sv
// ----------------------------------------------------------------------------
// Motion safety supervisor channels
// Request and response valid/ready channel interfaces.
// ----------------------------------------------------------------------------
interface msup_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         opcode;
   logic               estop_level;
   logic [23:0]        obstacle_distance;
   logic signed [23:0] speed;
   logic signed [31:0] position;

   modport source (
      output valid, opcode, estop_level, obstacle_distance, speed, position,
      input  ready
   );
   modport sink (
      input  valid, opcode, estop_level, obstacle_distance, speed, position,
      output ready
   );
endinterface

interface msup_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         safety_state;
   logic [2:0]         fault_code;
   logic [4:0]         flag_vector;
   logic [2:0]         active_violations;
   logic [31:0]        estop_events;
   logic [31:0]        collision_count;
   logic [31:0]        speed_events;
   logic [31:0]        position_events;
   logic [31:0]        zone_events;
   logic [23:0]        peak_speed;
   logic signed [31:0] lowest_position;
   logic signed [31:0] highest_position;

   modport source (
      output valid, safety_state, fault_code, flag_vector, active_violations,
             estop_events, collision_count, speed_events, position_events,
             zone_events, peak_speed, lowest_position, highest_position,
      input  ready
   );
   modport sink (
      input  valid, safety_state, fault_code, flag_vector, active_violations,
             estop_events, collision_count, speed_events, position_events,
             zone_events, peak_speed, lowest_position, highest_position,
      output ready
   );
endinterface

FILE: rtl/core/msup_front.sv
// ----------------------------------------------------------------------------
// Motion safety supervisor front end
// Accepts requests, decodes the opcode and evaluates the sample-only checks.
// ----------------------------------------------------------------------------
module msup_front (
   input  logic                  clock,
   input  logic                  reset,
   input  msup_pkg::cfg_type     cfg,
   msup_req_if.sink              req,
   input  msup_pkg::q_status_type q_status,
   output logic                  q_push,
   output msup_pkg::item_type    q_item
);
   import msup_pkg::*;

   logic     valid_ff;
   item_type item_ff;
   item_type item_in;
   logic     take;

   assign q_push    = valid_ff && !q_status.full;
   assign req.ready = !valid_ff || !q_status.full;
   assign take      = req.valid && req.ready;
   assign q_item    = item_ff;

   always_comb begin
      item_in             = '0;
      item_in.estop_level = req.estop_level;
      item_in.position    = req.position;
      item_in.speed_mag   = req.speed[23] ? $unsigned(~req.speed + 24'sd1)
                                          : $unsigned(req.speed);
      item_in.coll_hit    = req.obstacle_distance < cfg.collision_threshold;
      item_in.over_hit    = item_in.speed_mag > {1'b0, cfg.speed_ceiling};
      item_in.travel_hit  = ($signed(req.position) < $signed(cfg.travel_min)) ||
                            ($signed(req.position) > $signed(cfg.travel_max));
      case (req.opcode)
         OP_TICK:          item_in.cmd = CMD_TICK;
         OP_FORCE_ESTOP:   item_in.cmd = CMD_FORCE_ESTOP;
         OP_RELEASE_ESTOP: item_in.cmd = CMD_RELEASE_ESTOP;
         OP_CLEAR_FAULTS:  item_in.cmd = CMD_CLEAR_FAULTS;
         OP_RESET_STATS:   item_in.cmd = CMD_RESET_STATS;
         default:          item_in.cmd = CMD_REPORT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= 1'b1;
      end else if (q_push) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

FILE: rtl/core/msup_queue.sv
// ----------------------------------------------------------------------------
// Motion safety supervisor command queue
// Small FIFO between the front end and the execution back end.
// ----------------------------------------------------------------------------
module msup_queue #(
   parameter int DEPTH = msup_pkg::MSUP_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  msup_pkg::item_type     push_item,
   input  logic                   pop,
   output msup_pkg::item_type     head_item,
   output msup_pkg::q_status_type status
);
   import msup_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   item_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_in;

   assign status.full  = count_ff == CNT_W'(DEPTH);
   assign status.empty = count_ff == '0;
   assign head_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: rtl/core/msup_back.sv
// ----------------------------------------------------------------------------
// Motion safety supervisor back end
// Executes commands: edge latches, event counters, state, fault, statistics.
// ----------------------------------------------------------------------------
module msup_back (
   input  logic                   clock,
   input  logic                   reset,
   input  msup_pkg::cfg_type      cfg,
   input  msup_pkg::q_status_type q_status,
   input  msup_pkg::item_type     item,
   output logic                   q_pop,
   msup_rsp_if.source             rsp
);
   import msup_pkg::*;

   logic               rsp_valid_ff;
   logic [4:0]         latch_ff, latch_in;
   logic [4:0]         flags_ff, flags_in;
   safety_type         state_ff, state_in;
   fault_type          fault_ff, fault_in;
   logic [2:0]         active_ff, active_in;
   logic [23:0]        held_mag_ff, held_mag_in;
   logic signed [31:0] held_pos_ff, held_pos_in;
   logic [31:0]        events_ff [NUM_CHECKS];
   logic [31:0]        events_in [NUM_CHECKS];
   logic [23:0]        peak_ff, peak_in;
   logic signed [31:0] low_ff, low_in;
   logic signed [31:0] high_ff, high_in;
   logic [4:0]         en;
   logic [4:0]         hit;
   logic               zone_hit;
   logic [23:0]        zone_min;
   logic [23:0]        zone_max;
   logic [23:0]        mag_sel;
   logic signed [31:0] pos_sel;

   assign q_pop    = !q_status.empty && (!rsp_valid_ff || rsp.ready);
   assign en       = cfg.enable_mask;
   assign zone_min = cfg.zone_speed_band[23:0];
   assign zone_max = cfg.zone_speed_band[47:24];
   assign mag_sel  = en[FLAG_SPEED] ? item.speed_mag : held_mag_ff;
   assign pos_sel  = en[FLAG_POSITION] ? item.position : held_pos_ff;
   assign zone_hit = ($signed(pos_sel) < $signed(cfg.zone_pos_min)) ||
                     ($signed(pos_sel) > $signed(cfg.zone_pos_max)) ||
                     (mag_sel < zone_min) || (mag_sel > zone_max);
   assign hit      = {zone_hit, item.travel_hit, item.over_hit, item.coll_hit,
                      item.estop_level};

   always_comb begin
      latch_in    = latch_ff;
      flags_in    = flags_ff;
      state_in    = state_ff;
      fault_in    = fault_ff;
      held_mag_in = held_mag_ff;
      held_pos_in = held_pos_ff;
      events_in   = events_ff;
      peak_in     = peak_ff;
      low_in      = low_ff;
      high_in     = high_ff;
      case (item.cmd)
         CMD_TICK: begin
            held_mag_in = mag_sel;
            held_pos_in = pos_sel;
            for (int i = 0; i < NUM_CHECKS; i++) begin
               if (en[i] && hit[i] && !latch_ff[i]) begin
                  latch_in[i]  = 1'b1;
                  flags_in[i]  = 1'b1;
                  events_in[i] = events_ff[i] + 32'd1;
               end else if (en[i] && !hit[i] && latch_ff[i]) begin
                  latch_in[i] = 1'b0;
                  flags_in[i] = 1'b0;
               end
            end
            if (flags_in[FLAG_ESTOP]) begin
               state_in = STATE_EMERGENCY;
               fault_in = FAULT_ESTOP;
            end else if (flags_in[FLAG_COLLISION]) begin
               state_in = STATE_EMERGENCY;
               fault_in = FAULT_COLLISION;
            end else if (flags_in[FLAG_SPEED]) begin
               state_in = STATE_VIOLATION;
               fault_in = FAULT_SPEED;
            end else if (flags_in[FLAG_POSITION]) begin
               state_in = STATE_VIOLATION;
               fault_in = FAULT_POSITION;
            end else if (flags_in[FLAG_ZONE]) begin
               state_in = STATE_WARNING;
               fault_in = FAULT_NONE;
            end else begin
               state_in = STATE_SAFE;
               fault_in = FAULT_NONE;
            end
            if (mag_sel > peak_ff) begin
               peak_in = mag_sel;
            end
            if ($signed(pos_sel) < $signed(low_ff)) begin
               low_in = pos_sel;
            end
            if ($signed(pos_sel) > $signed(high_ff)) begin
               high_in = pos_sel;
            end
         end
         CMD_FORCE_ESTOP: begin
            latch_in[FLAG_ESTOP]  = 1'b1;
            flags_in[FLAG_ESTOP]  = 1'b1;
            events_in[FLAG_ESTOP] = events_ff[FLAG_ESTOP] + 32'd1;
            state_in              = STATE_EMERGENCY;
            fault_in              = FAULT_ESTOP;
         end
         CMD_RELEASE_ESTOP: begin
            latch_in[FLAG_ESTOP] = 1'b0;
            flags_in[FLAG_ESTOP] = 1'b0;
            if (fault_ff == FAULT_ESTOP) begin
               fault_in = FAULT_NONE;
               state_in = STATE_SAFE;
            end
         end
         CMD_CLEAR_FAULTS: begin
            state_in = STATE_SAFE;
            fault_in = FAULT_NONE;
            flags_in = flags_ff & 5'b00001;
         end
         CMD_RESET_STATS: begin
            events_in[FLAG_ESTOP]     = '0;
            events_in[FLAG_COLLISION] = '0;
            events_in[FLAG_SPEED]     = '0;
            events_in[FLAG_POSITION]  = '0;
            peak_in                   = '0;
            low_in                    = '0;
            high_in                   = '0;
         end
         default: begin
         end
      endcase
      active_in = 3'($countones(flags_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         latch_ff     <= '0;
         flags_ff     <= '0;
         state_ff     <= STATE_SAFE;
         fault_ff     <= FAULT_NONE;
         active_ff    <= '0;
         held_mag_ff  <= '0;
         held_pos_ff  <= '0;
         events_ff    <= '{default: '0};
         peak_ff      <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
      end else begin
         if (q_pop) begin
            rsp_valid_ff <= 1'b1;
            latch_ff     <= latch_in;
            flags_ff     <= flags_in;
            state_ff     <= state_in;
            fault_ff     <= fault_in;
            active_ff    <= active_in;
            held_mag_ff  <= held_mag_in;
            held_pos_ff  <= held_pos_in;
            events_ff    <= events_in;
            peak_ff      <= peak_in;
            low_ff       <= low_in;
            high_ff      <= high_in;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.safety_state      = state_ff;
   assign rsp.fault_code        = fault_ff;
   assign rsp.flag_vector       = flags_ff;
   assign rsp.active_violations = active_ff;
   assign rsp.estop_events      = events_ff[FLAG_ESTOP];
   assign rsp.collision_count   = events_ff[FLAG_COLLISION];
   assign rsp.speed_events      = events_ff[FLAG_SPEED];
   assign rsp.position_events   = events_ff[FLAG_POSITION];
   assign rsp.zone_events       = events_ff[FLAG_ZONE];
   assign rsp.peak_speed        = peak_ff;
   assign rsp.lowest_position   = low_ff;
   assign rsp.highest_position  = high_ff;

endmodule

FILE: rtl/core/motion_safety_supervisor.sv
// ----------------------------------------------------------------------------
// Motion safety supervisor
// E-stop, collision, speed, travel and zone supervision with event statistics.
// ----------------------------------------------------------------------------
// channel    dir  transfer when         payload
// req_chan   in   valid && ready        opcode, sensor samples
// rsp_chan   out  valid && ready        state, fault, flags, counters, stats
// csr_*      in   csr_write_en          index, 48-bit data
//
// One request per cycle sustained while the response side accepts; a request
// passes the front register, queue and back end state/output register.
// The back end updates all state once per popped command.
// Sync active-high reset clears all but front/queue data; no clearing pass.
// A stalled response backs up into the queue, then stalls the front end.
// ----------------------------------------------------------------------------
`include "motion_safety_supervisor_defines.svh"

module motion_safety_supervisor #(
   parameter int QUEUE_DEPTH = msup_pkg::MSUP_QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   msup_req_if.sink                           req_chan,
   msup_rsp_if.source                         rsp_chan,
   input  logic                               csr_write_en,
   input  logic [msup_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [msup_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import msup_pkg::*;

   cfg_type      cfg_ff;
   q_status_type q_status;
   item_type     push_item;
   item_type     head_item;
   logic         q_push;
   logic         q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ENABLE_MASK:     cfg_ff.enable_mask         <= csr_write_data[4:0];
            CSR_COLL_THRESHOLD:  cfg_ff.collision_threshold <= csr_write_data[23:0];
            CSR_SPEED_CEILING:   cfg_ff.speed_ceiling       <= csr_write_data[22:0];
            CSR_TRAVEL_MIN:      cfg_ff.travel_min          <= csr_write_data[31:0];
            CSR_TRAVEL_MAX:      cfg_ff.travel_max          <= csr_write_data[31:0];
            CSR_ZONE_POS_MIN:    cfg_ff.zone_pos_min        <= csr_write_data[31:0];
            CSR_ZONE_POS_MAX:    cfg_ff.zone_pos_max        <= csr_write_data[31:0];
            CSR_ZONE_SPEED_BAND: cfg_ff.zone_speed_band     <= csr_write_data[47:0];
            default: begin
            end
         endcase
      end
   end

   msup_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req      (req_chan),
      .q_status (q_status),
      .q_push   (q_push),
      .q_item   (push_item)
   );

   msup_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .status    (q_status)
   );

   msup_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_status (q_status),
      .item     (head_item),
      .q_pop    (q_pop),
      .rsp      (rsp_chan)
   );

   `MSUP_ASSERT_NEVER(a_queue_overflow, clock, reset,
                      q_push && q_status.full && !q_pop, "queue overflow")
   `MSUP_ASSERT_NEVER(a_queue_underflow, clock, reset,
                      q_pop && q_status.empty, "queue underflow")
   `MSUP_ASSERT(a_active_count, clock, reset,
                rsp_chan.valid |->
                (rsp_chan.active_violations == 3'($countones(rsp_chan.flag_vector))),
                "active count mismatch")
   `MSUP_ASSERT(a_emergency_fault, clock, reset,
                rsp_chan.valid |->
                ((rsp_chan.fault_code == FAULT_ESTOP ||
                  rsp_chan.fault_code == FAULT_COLLISION) ==
                 (rsp_chan.safety_state == STATE_EMERGENCY)),
                "emergency state and fault disagree")

endmodule

FILE: tb/msup_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Motion safety supervisor scoreboard
// Request and report types plus a scoreboard that predicts the report for
// each accepted request from its own copy of the registers and supervisor
// state, and compares arriving reports field by field in order.
// ----------------------------------------------------------------------------
package msup_tb_pkg;
   import msup_pkg::*;

   // opcodes with no function; the block only reports
   localparam logic [2:0] OP_SPARE_5 = 3'd5;
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [2:0]         opcode;
      logic               estop_level;
      logic [23:0]        obstacle_distance;
      logic signed [23:0] speed;
      logic signed [31:0] position;
   } sample_req_type;

   typedef struct packed {
      logic [1:0]                  safety_state;
      logic [2:0]                  fault_code;
      logic [4:0]                  flag_vector;
      logic [2:0]                  active_violations;
      logic [NUM_CHECKS-1:0][31:0] events;
      logic [23:0]                 peak_speed;
      logic [31:0]                 lowest_position;
      logic [31:0]                 highest_position;
   } status_report_type;

   class safety_scoreboard;
      logic [4:0]            enable_mask;
      logic [23:0]           collision_threshold;
      logic [22:0]           speed_ceiling;
      logic signed [31:0]    travel_min;
      logic signed [31:0]    travel_max;
      logic signed [31:0]    zone_pos_min;
      logic signed [31:0]    zone_pos_max;
      logic [23:0]           zone_speed_min;
      logic [23:0]           zone_speed_max;

      logic [NUM_CHECKS-1:0] latched;
      logic [NUM_CHECKS-1:0] flags;
      safety_type            state;
      fault_type             fault;
      logic signed [23:0]    held_speed;
      logic signed [31:0]    held_position;
      logic [31:0]           event_count [NUM_CHECKS];
      logic [23:0]           speed_peak;
      logic signed [31:0]    position_low;
      logic signed [31:0]    position_high;

      status_report_type     expected_reports [$];
      string                 counter_names [NUM_CHECKS];
      int                    error_count;

      function new();
         enable_mask         = '0;
         collision_threshold = '0;
         speed_ceiling       = '0;
         travel_min          = '0;
         travel_max          = '0;
         zone_pos_min        = '0;
         zone_pos_max        = '0;
         zone_speed_min      = '0;
         zone_speed_max      = '0;
         latched             = '0;
         flags               = '0;
         state               = STATE_SAFE;
         fault               = FAULT_NONE;
         held_speed          = '0;
         held_position       = '0;
         foreach (event_count[i]) event_count[i] = '0;
         speed_peak          = '0;
         position_low        = '0;
         position_high       = '0;
         counter_names       = '{"estop_events", "collision_count", "speed_events",
                                 "position_events", "zone_events"};
         error_count         = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_ENABLE_MASK:     enable_mask         = data[4:0];
            CSR_COLL_THRESHOLD:  collision_threshold = data[23:0];
            CSR_SPEED_CEILING:   speed_ceiling       = data[22:0];
            CSR_TRAVEL_MIN:      travel_min          = data[31:0];
            CSR_TRAVEL_MAX:      travel_max          = data[31:0];
            CSR_ZONE_POS_MIN:    zone_pos_min        = data[31:0];
            CSR_ZONE_POS_MAX:    zone_pos_max        = data[31:0];
            CSR_ZONE_SPEED_BAND: begin
               zone_speed_min = data[23:0];
               zone_speed_max = data[47:24];
            end
            default: ;
         endcase
      endfunction

      static function logic [23:0] magnitude(logic signed [23:0] v);
         return v[23] ? 24'(-v) : 24'(v);
      endfunction

      // rising condition latches, flags and counts; falling clears
      function void track(int idx, bit hit);
         if (hit && !latched[idx]) begin
            latched[idx]     = 1'b1;
            flags[idx]       = 1'b1;
            event_count[idx] = event_count[idx] + 32'd1;
         end else if (!hit && latched[idx]) begin
            latched[idx] = 1'b0;
            flags[idx]   = 1'b0;
         end
      endfunction

      function void run_tick(sample_req_type r);
         logic [23:0] speed_mag;
         if (enable_mask[FLAG_ESTOP])
            track(FLAG_ESTOP, r.estop_level);
         if (enable_mask[FLAG_COLLISION])
            track(FLAG_COLLISION, r.obstacle_distance < collision_threshold);
         if (enable_mask[FLAG_SPEED]) begin
            held_speed = r.speed;
            track(FLAG_SPEED, magnitude(held_speed) > {1'b0, speed_ceiling});
         end
         if (enable_mask[FLAG_POSITION]) begin
            held_position = r.position;
            track(FLAG_POSITION, held_position < travel_min || held_position > travel_max);
         end
         speed_mag = magnitude(held_speed);
         if (enable_mask[FLAG_ZONE])
            track(FLAG_ZONE, held_position < zone_pos_min || held_position > zone_pos_max ||
                             speed_mag < zone_speed_min || speed_mag > zone_speed_max);

         if (flags[FLAG_ESTOP]) begin
            state = STATE_EMERGENCY;
            fault = FAULT_ESTOP;
         end else if (flags[FLAG_COLLISION]) begin
            state = STATE_EMERGENCY;
            fault = FAULT_COLLISION;
         end else if (flags[FLAG_SPEED]) begin
            state = STATE_VIOLATION;
            fault = FAULT_SPEED;
         end else if (flags[FLAG_POSITION]) begin
            state = STATE_VIOLATION;
            fault = FAULT_POSITION;
         end else if (flags[FLAG_ZONE]) begin
            state = STATE_WARNING;
            fault = FAULT_NONE;
         end else begin
            state = STATE_SAFE;
            fault = FAULT_NONE;
         end

         if (speed_mag > speed_peak) speed_peak = speed_mag;
         if (held_position < position_low) position_low = held_position;
         if (held_position > position_high) position_high = held_position;
      endfunction

      function void note_request(sample_req_type r);
         status_report_type rpt;
         case (r.opcode)
            OP_TICK: run_tick(r);
            OP_FORCE_ESTOP: begin
               latched[FLAG_ESTOP]     = 1'b1;
               flags[FLAG_ESTOP]       = 1'b1;
               event_count[FLAG_ESTOP] = event_count[FLAG_ESTOP] + 32'd1;
               state = STATE_EMERGENCY;
               fault = FAULT_ESTOP;
            end
            OP_RELEASE_ESTOP: begin
               latched[FLAG_ESTOP] = 1'b0;
               flags[FLAG_ESTOP]   = 1'b0;
               if (fault == FAULT_ESTOP) begin
                  fault = FAULT_NONE;
                  state = STATE_SAFE;
               end
            end
            OP_CLEAR_FAULTS: begin
               fault = FAULT_NONE;
               state = STATE_SAFE;
               flags = flags & (NUM_CHECKS'(1) << FLAG_ESTOP);
            end
            OP_RESET_STATS: begin
               event_count[FLAG_ESTOP]     = '0;
               event_count[FLAG_COLLISION] = '0;
               event_count[FLAG_SPEED]     = '0;
               event_count[FLAG_POSITION]  = '0;
               speed_peak    = '0;
               position_low  = '0;
               position_high = '0;
            end
            default: ;
         endcase

         rpt.safety_state      = state;
         rpt.fault_code        = fault;
         rpt.flag_vector       = flags;
         rpt.active_violations = 3'($countones(flags));
         for (int i = 0; i < NUM_CHECKS; i++) rpt.events[i] = event_count[i];
         rpt.peak_speed        = speed_peak;
         rpt.lowest_position   = position_low;
         rpt.highest_position  = position_high;
         expected_reports.push_back(rpt);
      endfunction

      function void compare(string field, logic signed [63:0] want,
                            logic signed [63:0] seen);
         if (seen !== want) begin
            $error("%s: expected %0d, actual %0d", field, want, seen);
            error_count++;
         end
      endfunction

      function void check_response(status_report_type got);
         status_report_type want;
         if (expected_reports.size() == 0) begin
            $error("report transfer with no request outstanding");
            error_count++;
            return;
         end
         want = expected_reports.pop_front();
         compare("safety_state", want.safety_state, got.safety_state);
         compare("fault_code", want.fault_code, got.fault_code);
         compare("flag_vector", want.flag_vector, got.flag_vector);
         compare("active_violations", want.active_violations, got.active_violations);
         for (int i = 0; i < NUM_CHECKS; i++)
            compare(counter_names[i], want.events[i], got.events[i]);
         compare("peak_speed", want.peak_speed, got.peak_speed);
         compare("lowest_position", $signed(want.lowest_position),
                 $signed(got.lowest_position));
         compare("highest_position", $signed(want.highest_position),
                 $signed(got.highest_position));
      endfunction
   endclass

endpackage

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Motion safety supervisor testbench
// Directed ticks and commands around every threshold, then random phases
// over several register settings with sender gaps and receiver stalls.
// Every report is checked against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import msup_pkg::*;
   import msup_tb_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   int                     src_idle_pct;
   int                     rsp_stall_pct;
   sample_req_type         prev_req;
   safety_scoreboard       sb;

   msup_req_if req_if ();
   msup_rsp_if rsp_if ();

   motion_safety_supervisor dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_if),
      .rsp_chan       (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("motion_safety_supervisor: mismatch");
      $finish;
   end

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : monitor
      sample_req_type    req;
      status_report_type got;
      if (!reset && req_if.valid && req_if.ready) begin
         req.opcode            = req_if.opcode;
         req.estop_level       = req_if.estop_level;
         req.obstacle_distance = req_if.obstacle_distance;
         req.speed             = req_if.speed;
         req.position          = req_if.position;
         sb.note_request(req);
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.safety_state              = rsp_if.safety_state;
         got.fault_code                = rsp_if.fault_code;
         got.flag_vector               = rsp_if.flag_vector;
         got.active_violations         = rsp_if.active_violations;
         got.events[FLAG_ESTOP]        = rsp_if.estop_events;
         got.events[FLAG_COLLISION]    = rsp_if.collision_count;
         got.events[FLAG_SPEED]        = rsp_if.speed_events;
         got.events[FLAG_POSITION]     = rsp_if.position_events;
         got.events[FLAG_ZONE]         = rsp_if.zone_events;
         got.peak_speed                = rsp_if.peak_speed;
         got.lowest_position           = rsp_if.lowest_position;
         got.highest_position          = rsp_if.highest_position;
         sb.check_response(got);
      end
   end

   function automatic sample_req_type sample(logic [2:0] op, logic estop, logic [23:0] gap,
                                             logic signed [23:0] spd, logic signed [31:0] pos);
      sample_req_type r;
      r.opcode            = op;
      r.estop_level       = estop;
      r.obstacle_distance = gap;
      r.speed             = spd;
      r.position          = pos;
      return r;
   endfunction

   function automatic logic [31:0] jitter(logic [31:0] mark);
      return mark + 32'($urandom_range(6)) - 32'd3;
   endfunction

   function automatic logic [23:0] pick_distance();
      logic [23:0] d;
      case ($urandom_range(5))
         0:       d = 24'($urandom);
         1:       d = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
         2, 3:    d = 24'(jitter({8'd0, sb.collision_threshold}));
         default: d = 24'($urandom_range(40000));
      endcase
      return d;
   endfunction

   function automatic logic signed [23:0] pick_speed();
      logic [23:0] m;
      case ($urandom_range(9))
         0:       return 24'($urandom);
         1: begin
            case ($urandom_range(2))
               0:       return 24'sh800000;
               1:       return 24'sh7FFFFF;
               default: return 24'sh000000;
            endcase
         end
         2, 3:    m = 24'(jitter({9'd0, sb.speed_ceiling}));
         4:       m = 24'(jitter({8'd0, sb.zone_speed_min}));
         5:       m = 24'(jitter({8'd0, sb.zone_speed_max}));
         default: m = 24'($urandom_range(30000));
      endcase
      return $urandom_range(1) ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [31:0] pick_position();
      logic [31:0] p;
      case ($urandom_range(9))
         0:       p = $urandom;
         1:       p = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
         2:       p = jitter(sb.travel_min);
         3:       p = jitter(sb.travel_max);
         4:       p = jitter(sb.zone_pos_min);
         5:       p = jitter(sb.zone_pos_max);
         default: p = 32'($urandom_range(400000)) - 32'd200000;
      endcase
      return $signed(p);
   endfunction

   // mostly ticks; sensor readings often held over to exercise the latches
   function automatic sample_req_type random_request();
      sample_req_type r;
      int             pick;
      pick = $urandom_range(99);
      if (pick < 70)      r.opcode = OP_TICK;
      else if (pick < 77) r.opcode = OP_FORCE_ESTOP;
      else if (pick < 84) r.opcode = OP_RELEASE_ESTOP;
      else if (pick < 90) r.opcode = OP_CLEAR_FAULTS;
      else if (pick < 95) r.opcode = OP_RESET_STATS;
      else begin
         case ($urandom_range(2))
            0:       r.opcode = OP_SPARE_5;
            1:       r.opcode = OP_SPARE_6;
            default: r.opcode = OP_SPARE_7;
         endcase
      end
      if ($urandom_range(99) < 30) begin
         r.estop_level       = prev_req.estop_level;
         r.obstacle_distance = prev_req.obstacle_distance;
         r.speed             = prev_req.speed;
         r.position          = prev_req.position;
      end else begin
         r.estop_level       = ($urandom_range(99) < 30);
         r.obstacle_distance = pick_distance();
         r.speed             = pick_speed();
         r.position          = pick_position();
      end
      return r;
   endfunction

   task automatic send_req(sample_req_type item);
      while ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid             <= 1'b1;
      req_if.opcode            <= item.opcode;
      req_if.estop_level       <= item.estop_level;
      req_if.obstacle_distance <= item.obstacle_distance;
      req_if.speed             <= item.speed;
      req_if.position          <= item.position;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      prev_req = item;
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value,
                            int width);
      logic [CSR_DATA_W-1:0] data;
      // bits above the register width are don't-care
      data = (CSR_DATA_W'({$urandom, $urandom}) << width) | value;
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= data;
      sb.write_register(index, data);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic configure(int setting);
      logic [4:0]  mask;
      logic [23:0] thr;
      logic [22:0] lim;
      logic [31:0] tmin, tmax, zmin, zmax;
      logic [47:0] band;
      case (setting)
         0: begin
            mask = 5'h1F;         thr  = 24'd1000;       lim  = 23'd5000;
            tmin = -32'sd100000;  tmax = 32'sd100000;
            zmin = -32'sd50000;   zmax = 32'sd50000;     band = {24'd4000, 24'd100};
         end
         1: begin
            mask = 5'h1F;         thr  = 24'h000000;     lim  = 23'h7FFFFF;
            tmin = 32'h80000000;  tmax = 32'h7FFFFFFF;
            zmin = 32'h80000000;  zmax = 32'h7FFFFFFF;   band = {24'hFFFFFF, 24'h000000};
         end
         2: begin
            mask = 5'h1F;         thr  = 24'hFFFFFF;     lim  = 23'h000000;
            tmin = 32'h00000000;  tmax = 32'h00000000;
            zmin = 32'h7FFFFFFF;  zmax = 32'h80000000;   band = {24'h000000, 24'hFFFFFF};
         end
         4: begin
            mask = (5'd1 << FLAG_SPEED) | (5'd1 << FLAG_ZONE);
            thr  = 24'd2000;      lim  = 23'd8000;
            tmin = -32'sd20000;   tmax = 32'sd20000;
            zmin = -32'sd10000;   zmax = 32'sd10000;     band = {24'd6000, 24'd500};
         end
         6: begin
            mask = 5'h00;         thr  = 24'($urandom);  lim  = 23'($urandom);
            tmin = $urandom;      tmax = $urandom;
            zmin = $urandom;      zmax = $urandom;       band = 48'({$urandom, $urandom});
         end
         default: begin
            mask = 5'($urandom);
            thr  = 24'($urandom_range(20000));
            lim  = 23'($urandom_range(20000));
            tmin = -32'($urandom_range(200000));
            tmax = 32'($urandom_range(200000));
            zmin = -32'($urandom_range(100000));
            zmax = 32'($urandom_range(100000));
            band = {24'($urandom_range(2000, 30000)), 24'($urandom_range(2000))};
         end
      endcase
      write_csr(CSR_ENABLE_MASK, 48'(mask), 5);
      write_csr(CSR_COLL_THRESHOLD, 48'(thr), 24);
      write_csr(CSR_SPEED_CEILING, 48'(lim), 23);
      write_csr(CSR_TRAVEL_MIN, 48'(tmin), 32);
      write_csr(CSR_TRAVEL_MAX, 48'(tmax), 32);
      write_csr(CSR_ZONE_POS_MIN, 48'(zmin), 32);
      write_csr(CSR_ZONE_POS_MAX, 48'(zmax), 32);
      write_csr(CSR_ZONE_SPEED_BAND, band, 48);
   endtask

   initial begin
      sb                       = new();
      reset                    = 1'b1;
      csr_write_en             = 1'b0;
      csr_index                = '0;
      csr_write_data           = '0;
      req_if.valid             = 1'b0;
      req_if.opcode            = OP_TICK;
      req_if.estop_level       = 1'b0;
      req_if.obstacle_distance = '0;
      req_if.speed             = '0;
      req_if.position          = '0;
      rsp_if.ready             = 1'b0;
      src_idle_pct             = 0;
      rsp_stall_pct            = 0;
      prev_req                 = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      configure(0);
      send_req(sample(OP_TICK, 1'b0, 24'd5000, 24'sd1000, 32'sd0));
      send_req(sample(OP_TICK, 1'b0, 24'd5000, 24'sd50, 32'sd0));          // zone only
      send_req(sample(OP_TICK, 1'b0, 24'd5000, 24'sd1000, 32'sd150000));   // out of travel
      send_req(sample(OP_TICK, 1'b0, 24'd5000, -24'sd6000, 32'sd0));       // overspeed
      send_req(sample(OP_TICK, 1'b0, 24'd999, 24'sd1000, 32'sd0));         // collision
      send_req(sample(OP_TICK, 1'b0, 24'd1000, 24'sd5000, 32'sd100000));   // on the bounds
      send_req(sample(OP_TICK, 1'b1, 24'hFFFFFF, 24'sh7FFFFF, 32'sh7FFFFFFF));
      send_req(sample(OP_TICK, 1'b1, 24'hFFFFFF, 24'sh7FFFFF, 32'sh7FFFFFFF));
      send_req(sample(OP_CLEAR_FAULTS, 1'b0, 24'd0, 24'sd0, 32'sd0));
      // latches still held after clear: no new events, only the e-stop flag stays set
      send_req(sample(OP_TICK, 1'b1, 24'hFFFFFF, 24'sh7FFFFF, 32'sh7FFFFFFF));
      send_req(sample(OP_TICK, 1'b0, 24'd0, 24'sh800000, 32'sh80000000));
      send_req(sample(OP_TICK, 1'b0, 24'd5000, 24'sd1000, 32'sd0));
      send_req(sample(OP_FORCE_ESTOP, 1'b0, 24'd0, 24'sd0, 32'sd0));
      send_req(sample(OP_FORCE_ESTOP, 1'b0, 24'hFFFFFF, 24'sd0, 32'sd0));
      send_req(sample(OP_RELEASE_ESTOP, 1'b1, 24'd0, 24'sd0, 32'sd0));
      send_req(sample(OP_TICK, 1'b0, 24'd5000, -24'sd6000, 32'sd0));
      send_req(sample(OP_RELEASE_ESTOP, 1'b0, 24'd0, 24'sd0, 32'sd0));  // speed fault kept
      send_req(sample(OP_RESET_STATS, 1'b1, 24'd0, 24'sh800000, 32'sh80000000));
      send_req(sample(OP_SPARE_5, 1'b1, 24'd0, 24'sh800000, 32'sh80000000));
      send_req(sample(OP_SPARE_6, 1'b1, 24'hFFFFFF, 24'sh7FFFFF, 32'sh7FFFFFFF));
      send_req(sample(OP_SPARE_7, 1'b0, 24'h555555, 24'shAAAAAA, 32'sh5555AAAA));
      send_req(sample(OP_TICK, 1'b0, 24'hFFFFFF, 24'sd0, 32'sd0));
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin src_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin src_idle_pct = 75; rsp_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  rsp_stall_pct = 75; end
            default: begin src_idle_pct = 20; rsp_stall_pct = 20; end
         endcase
         configure(phase);
         repeat (85) send_req(random_request());
         wait_idle();
      end

      if (sb.error_count == 0)
         $display("motion_safety_supervisor: match");
      else
         $display("motion_safety_supervisor: mismatch");
      $finish;
   end

endmodule
